/* sv/ptm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_pkg
// Shared types and constants of the two-level page table manager.
// ----------------------------------------------------------------------------
package ptm_pkg;

  // Entry word layout and table geometry
  localparam int IDX_W          = 10;
  localparam int ENTRIES        = 1024;
  localparam int FRAME_W        = 20;
  localparam int ATTR_W         = 3;
  localparam int WORD_W         = 32;
  localparam int FIRST_FREE_W   = 6;
  localparam int FIRST_FREE_RST = 8;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_UNMAP = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_BEYOND   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    MEM_IDLE,
    MEM_RD_DIR,
    MEM_RD_TBL,
    MEM_WR_DIR,
    MEM_WR_TBL,
    MEM_CLR_ALL,
    MEM_CLR_TBL
  } mem_cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIR_EVAL,
    S_TBL_CLR,
    S_DIR_WR,
    S_TBL_WR,
    S_TBL_RD,
    S_TBL_EVAL,
    S_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic     load_in;
    mem_cmd_t mem_cmd;
    logic     cnt_inc;
    logic     cap_dir;
    logic     take_frame;
    logic     cap_pres;
    logic     set_status;
    status_t  status;
    logic     out_load;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic dframe_big;
    logic dir_pres;
    logic dir_big;
    logic nf_big;
    logic sweep_last;
    logic tbl_last;
    logic out_free;
  } dp_stat_t;

endpackage

/* sv/ptm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_if
// Valid/ready channels of the page table manager: request, result, config.
// ----------------------------------------------------------------------------
interface ptm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] virt_addr;
  logic [19:0] dir_frame;
  logic [31:0] phys_addr;
  logic [2:0]  attr;

  modport source (output valid, op, virt_addr, dir_frame, phys_addr, attr, input ready);
  modport sink   (input valid, op, virt_addr, dir_frame, phys_addr, attr, output ready);
endinterface

interface ptm_out_if;
  logic        valid;
  logic        ready;
  logic        present;
  logic [1:0]  status;
  logic [19:0] table_frame;
  logic        allocated;

  modport source (output valid, present, status, table_frame, allocated, input ready);
  modport sink   (input valid, present, status, table_frame, allocated, output ready);
endinterface

interface ptm_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* sv/ptm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_ctrl
// Sequencer of the page table manager: reset sweep, walk, allocation, reply.
// ----------------------------------------------------------------------------
module ptm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ptm_pkg::dp_stat_t  stat,
  output ptm_pkg::ctrl_cmd_t cmd
);
  import ptm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (stat.op == OP_NONE || stat.dframe_big) state_nxt = S_DONE;
        else state_nxt = S_DIR_EVAL;
      end
      S_DIR_EVAL: begin
        if (stat.op == OP_MAP) begin
          if (stat.dir_pres) state_nxt = stat.dir_big ? S_DONE : S_TBL_WR;
          else if (stat.nf_big) state_nxt = S_DONE;
          else state_nxt = S_TBL_CLR;
        end else if (!stat.dir_pres || stat.dir_big) begin
          state_nxt = S_DONE;
        end else if (stat.op == OP_UNMAP) begin
          state_nxt = S_TBL_WR;
        end else begin
          state_nxt = S_TBL_RD;
        end
      end
      S_TBL_CLR: begin
        if (stat.tbl_last) state_nxt = S_DIR_WR;
      end
      S_DIR_WR:   state_nxt = S_TBL_WR;
      S_TBL_WR:   state_nxt = S_DONE;
      S_TBL_RD:   state_nxt = S_TBL_EVAL;
      S_TBL_EVAL: state_nxt = S_DONE;
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.mem_cmd = MEM_CLR_ALL;
        cmd.cnt_inc = 1'b1;
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_CHECK: begin
        if (stat.op != OP_NONE) begin
          if (stat.dframe_big) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BEYOND;
          end else begin
            cmd.mem_cmd = MEM_RD_DIR;
          end
        end
      end
      S_DIR_EVAL: begin
        if (stat.dir_pres) begin
          cmd.cap_dir = 1'b1;
          if (stat.dir_big) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_BEYOND;
          end
        end else if (stat.op == OP_MAP) begin
          if (stat.nf_big) begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NO_FRAME;
          end else begin
            cmd.take_frame = 1'b1;
          end
        end
      end
      S_TBL_CLR: begin
        cmd.mem_cmd = MEM_CLR_TBL;
        cmd.cnt_inc = 1'b1;
      end
      S_DIR_WR:   cmd.mem_cmd  = MEM_WR_DIR;
      S_TBL_WR:   cmd.mem_cmd  = MEM_WR_TBL;
      S_TBL_RD:   cmd.mem_cmd  = MEM_RD_TBL;
      S_TBL_EVAL: cmd.cap_pres = 1'b1;
      S_DONE:     cmd.out_load = stat.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* sv/ptm_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptm_dpath
// Request registers, frame store, free-frame pointer and result register.
// ----------------------------------------------------------------------------
module ptm_dpath #(
  parameter int FRAMES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  ptm_in_if.sink             in_ch,
  ptm_out_if.source          out_ch,
  ptm_cfg_if.sink            cfg_ch,
  input  ptm_pkg::ctrl_cmd_t cmd,
  output ptm_pkg::dp_stat_t  stat
);
  import ptm_pkg::*;

  localparam int FW    = $clog2(FRAMES);
  localparam int AW    = FW + IDX_W;
  localparam int DEPTH = FRAMES * ENTRIES;
  localparam int NFW   = ($clog2(FRAMES + 1) > FIRST_FREE_W) ? $clog2(FRAMES + 1)
                                                              : FIRST_FREE_W;

  // Request fields
  op_t                op_r;
  logic [IDX_W-1:0]   di_r;
  logic [IDX_W-1:0]   ti_r;
  logic [FRAME_W-1:0] dframe_r;
  logic [FRAME_W-1:0] pframe_r;
  logic [ATTR_W-1:0]  attr_r;

  // Working result
  logic [FRAME_W-1:0] tframe_r;
  logic               present_r;
  status_t            status_r;
  logic               alloc_r;

  // Pointer, sweep counter, store
  logic [NFW-1:0]     nf_r;
  logic [AW-1:0]      cnt_r;
  logic [WORD_W-1:0]  mem [DEPTH];
  logic [WORD_W-1:0]  rdata_r;
  logic [AW-1:0]      mem_addr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               mem_we;
  logic               mem_re;

  // Result register
  logic               out_valid_r;
  logic               out_present_r;
  status_t            out_status_r;
  logic [FRAME_W-1:0] out_tframe_r;
  logic               out_alloc_r;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op_t'(in_ch.op);
      di_r     <= in_ch.virt_addr[31:22];
      ti_r     <= in_ch.virt_addr[21:12];
      dframe_r <= in_ch.dir_frame;
      pframe_r <= in_ch.phys_addr[31:12];
      attr_r   <= in_ch.attr;
    end
  end

  // Build the result fields
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tframe_r  <= '0;
      present_r <= 1'b0;
      status_r  <= ST_OK;
      alloc_r   <= 1'b0;
    end else begin
      if (cmd.take_frame) begin
        tframe_r <= FRAME_W'(nf_r);
        alloc_r  <= 1'b1;
      end else if (cmd.cap_dir) begin
        tframe_r <= rdata_r[31:12];
      end
      if (cmd.cap_pres) present_r <= rdata_r[0];
      if (cmd.set_status) status_r <= cmd.status;
    end
  end

  // Free-frame pointer: reload on config write, bump on allocation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= NFW'(FIRST_FREE_RST);
    end else if (cfg_ch.valid) begin
      nf_r <= NFW'(cfg_ch.data);
    end else if (cmd.take_frame) begin
      nf_r <= nf_r + NFW'(1);
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Sweep counter: whole store after reset, one table on allocation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.take_frame) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + AW'(1);
    end
  end

  // Store address and write data; an absent entry is never read for its
  // frame, so clearing and unmapping just drop the whole word
  always_comb begin
    mem_addr  = {dframe_r[FW-1:0], di_r};
    mem_wdata = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    case (cmd.mem_cmd)
      MEM_RD_DIR: begin
        mem_re = 1'b1;
      end
      MEM_WR_DIR: begin
        mem_we    = 1'b1;
        mem_wdata = {tframe_r, (WORD_W - FRAME_W - ATTR_W)'(0), attr_r};
      end
      MEM_RD_TBL: begin
        mem_addr = {tframe_r[FW-1:0], ti_r};
        mem_re   = 1'b1;
      end
      MEM_WR_TBL: begin
        mem_addr = {tframe_r[FW-1:0], ti_r};
        mem_we   = 1'b1;
        if (op_r == OP_MAP) begin
          mem_wdata = {pframe_r, (WORD_W - FRAME_W - ATTR_W)'(0), attr_r};
        end
      end
      MEM_CLR_TBL: begin
        mem_addr = {tframe_r[FW-1:0], cnt_r[IDX_W-1:0]};
        mem_we   = 1'b1;
      end
      MEM_CLR_ALL: begin
        mem_addr = cnt_r;
        mem_we   = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Frame store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_r <= mem[mem_addr];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_present_r <= present_r;
      out_status_r  <= status_r;
      out_tframe_r  <= tframe_r;
      out_alloc_r   <= alloc_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.present     = out_present_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.table_frame = out_tframe_r;
  assign out_ch.allocated   = out_alloc_r;

  // Status to the controller
  always_comb begin
    stat.op         = op_r;
    stat.dframe_big = dframe_r >= FRAME_W'(FRAMES);
    stat.dir_pres   = rdata_r[0];
    stat.dir_big    = rdata_r[31:12] >= FRAME_W'(FRAMES);
    stat.nf_big     = nf_r >= NFW'(FRAMES);
    stat.sweep_last = cnt_r == AW'(DEPTH - 1);
    stat.tbl_last   = cnt_r[IDX_W-1:0] == IDX_W'(ENTRIES - 1);
    stat.out_free   = !out_valid_r || out_ch.ready;
  end

endmodule

/* sv/two_level_page_table_manager.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_page_table_manager
// Map, unmap and query pages in x86-style two-level tables in a frame store.
// ----------------------------------------------------------------------------
//  channel | dir | fields                                        | transfer
//  in_ch   | in  | op, virt_addr, dir_frame, phys_addr, attr     | valid & ready
//  out_ch  | out | present, status, table_frame, allocated       | valid & ready
//  cfg_ch  | in  | data (first_free_frame)                       | valid & ready
//
//  A request runs through a directory read, a table read or write and the
//  result load; a map that allocates a table adds one store write per entry
//  plus the directory write, through the single port of the frame store.
//  After reset a clearing pass writes every store word before in_ch.ready
//  rises; cfg_ch is taken at any time.
//  A finished result waits in the output register; the next request is
//  accepted meanwhile and stalls only when its own result is ready to load.
// ----------------------------------------------------------------------------
module two_level_page_table_manager #(
  parameter int FRAMES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  ptm_in_if.sink    in_ch,
  ptm_out_if.source out_ch,
  ptm_cfg_if.sink   cfg_ch
);
  import ptm_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ptm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ptm_dpath #(
    .FRAMES (FRAMES)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .stat   (stat)
  );

endmodule
